@@ rtl/qch_pkg.sv @@
// Package for the quantized colour histogram block.
// Holds the payload structs, channel and state codes and the reciprocal table.
// No dependencies.
package qch_pkg;

  localparam int MAX_BINS_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 21;

  localparam int BC_W      = 5;   // bin_count register width
  localparam int FRAC_BITS = 16;  // fraction bits of the result
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int RECIP_W   = 17;
  localparam int CMP_W     = 8;   // common width for bin compares

  localparam logic [BC_W-1:0] BIN_COUNT_RST = 5'd16;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [1:0]        channel_index;
    logic [3:0]        bin_index;
    logic [FRAC_W-1:0] fraction;
    logic              last_result;
  } result_t;

  typedef enum logic [4:0] {
    S_ACC  = 5'b00001,
    S_RD   = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // floor(65536/n)+1: (v*R)>>16 == v/n exactly for 8-bit v and n up to 31
  localparam logic [RECIP_W-1:0] RECIP [32] = '{
    17'd65537, 17'd65537, 17'd32769, 17'd21846, 17'd16385, 17'd13108, 17'd10923, 17'd9363,
    17'd8193,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,  17'd4682,  17'd4370,
    17'd4097,  17'd3856,  17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850,
    17'd2731,  17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,  17'd2185,  17'd2115
  };

endpackage

@@ rtl/qch_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the histogram counters; no package dependency.
module qch_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/quantized_color_histogram_top.sv @@
// Quantized colour histogram, top level.
// Uses qch_pkg and one qch_ram instance for the counters of all three channels.
//
// Pixels arrive one per transfer, blue/green/red plus a last_pixel flag. Each
// channel value is divided by bin_count and counted in that channel's bin;
// quotients at or above bin_count only add to the pixel total. The counters
// share one memory port, read-modify-write once per channel; a new pixel is
// taken during the current one's red channel. After the last pixel it emits
// 3*bin_count fractions, floor(count*65536/total), blue first and bin 0 upward;
// each passes a memory read, a 17-bit shift-subtract divider and an output
// load, and may be held by a result-side stall. Pixels are refused while
// emitting; after that all counters and the total read zero again. Counters
// and the total saturate at 2^COUNT_WIDTH-1. Change bin_count only while idle.
module quantized_color_histogram_top #(
  parameter int MAX_BINS    = qch_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = qch_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  qch_pkg::pixel_t       pix,
  output logic                  res_valid,
  input  logic                  res_stall,
  output qch_pkg::result_t      res,
  input  logic                  cfg_write,
  input  logic [qch_pkg::BC_W-1:0] cfg_data
);

  import qch_pkg::*;

  localparam int DEPTH  = 3 * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW     = COUNT_WIDTH;

  state_t            state;
  logic [BC_W-1:0]   bin_count;
  logic [BC_W-1:0]   eff_bins;
  logic [CW-1:0]     total;
  logic [DEPTH-1:0]  vld;

  // accumulate side
  pixel_t            cur;
  logic              busy;
  logic [1:0]        ch;
  logic [7:0]        chan_val;
  logic [RECIP_W-1:0] recip;
  logic [24:0]       prod;
  logic [7:0]        quot;
  logic              hit;
  logic [ADDR_W-1:0] acc_addr;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [CW-1:0]     wr_cnt;
  logic              pix_xfer;

  // emission side
  logic [1:0]        e_chan;
  logic [BIN_W-1:0]  e_bin;
  logic [ADDR_W-1:0] e_addr;
  logic              e_last_bin;
  logic              e_last;
  logic [CW-1:0]     e_cnt;
  logic [CW-1:0]     rem;
  logic [CW:0]       trial;
  logic              trial_ge;
  logic [FRAC_W-1:0] quo;
  logic [3:0]        step;
  logic              res_load;

  logic [ADDR_W-1:0] raddr;
  logic [CW-1:0]     rdata;

  always_comb begin
    eff_bins = bin_count;
    if (bin_count == '0) begin
      eff_bins = BC_W'(1);
    end else if (32'(bin_count) > MAX_BINS) begin
      eff_bins = BC_W'(MAX_BINS);
    end
  end

  always_comb begin
    case (ch)
      CH_BLUE:  chan_val = cur.blue;
      CH_GREEN: chan_val = cur.green;
      default:  chan_val = cur.red;
    endcase
  end

  assign recip    = RECIP[eff_bins];
  assign prod     = 25'(chan_val) * 25'(recip);
  assign quot     = prod[23:16];
  assign hit      = quot < CMP_W'(eff_bins);
  assign acc_addr = ADDR_W'(ADDR_W'(ch) * ADDR_W'(MAX_BINS) + ADDR_W'(quot));

  assign pix_stall = !((state == S_ACC) && (!busy || (ch == CH_RED && !cur.last_pixel)));
  assign pix_xfer  = pix_valid && !pix_stall;

  assign wr_cnt = vld[wr_addr] ? ((rdata == '1) ? rdata : CW'(rdata + 1'b1)) : CW'(1);

  assign e_addr     = ADDR_W'(ADDR_W'(e_chan) * ADDR_W'(MAX_BINS) + ADDR_W'(e_bin));
  assign e_last_bin = CMP_W'(e_bin) == CMP_W'(eff_bins - 1'b1);
  assign e_last     = (e_chan == CH_RED) && e_last_bin;
  assign e_cnt      = vld[e_addr] ? rdata : '0;
  assign trial      = {rem, 1'b0};
  assign trial_ge   = trial >= {1'b0, total};
  assign res_load   = (state == S_OUT) && (!res_valid || !res_stall);

  assign raddr = (state == S_ACC) ? acc_addr : e_addr;

  qch_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (wr_pend),
    .waddr (wr_addr),
    .wdata (wr_cnt),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= BIN_COUNT_RST;
    end else if (cfg_write) begin
      bin_count <= cfg_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      busy      <= 1'b0;
      ch        <= CH_BLUE;
      wr_pend   <= 1'b0;
      total     <= '0;
      vld       <= '0;
      e_chan    <= CH_BLUE;
      e_bin     <= '0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      wr_pend <= (state == S_ACC) && busy && hit;
      if (wr_pend) begin
        vld[wr_addr] <= 1'b1;
      end
      if (pix_xfer && (total != '1)) begin
        total <= CW'(total + 1'b1);
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_ACC: begin
          if (pix_xfer) begin
            busy <= 1'b1;
            ch   <= CH_BLUE;
          end else if (busy) begin
            if (ch == CH_RED) begin
              busy <= 1'b0;
              if (cur.last_pixel) begin
                state <= S_RD;
              end
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        S_RD: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == 4'(FRAC_BITS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            if (e_last) begin
              e_chan <= CH_BLUE;
              e_bin  <= '0;
              vld    <= '0;
              total  <= '0;
              state  <= S_ACC;
            end else begin
              if (e_last_bin) begin
                e_bin  <= '0;
                e_chan <= e_chan + 1'b1;
              end else begin
                e_bin <= e_bin + 1'b1;
              end
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_ACC;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      cur <= pix;
    end
    if ((state == S_ACC) && busy) begin
      wr_addr <= acc_addr;
    end
    if (state == S_LOAD) begin
      if (e_cnt >= total) begin
        rem <= CW'(e_cnt - total);
        quo <= FRAC_W'(1);
      end else begin
        rem <= e_cnt;
        quo <= '0;
      end
    end else if (state == S_DIV) begin
      rem <= trial_ge ? CW'(trial - {1'b0, total}) : CW'(trial);
      quo <= {quo[FRAC_W-2:0], trial_ge};
    end
    if (res_load) begin
      res.channel_index <= e_chan;
      res.bin_index     <= 4'(e_bin);
      res.fraction      <= quo;
      res.last_result   <= e_last;
    end
  end

  a_wr_in_acc: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == S_ACC || state == S_RD))
    else $error("counter write outside accumulation");

  a_rem_below_total: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < total))
    else $error("divider remainder not below pixel total");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (quo <= FRAC_W'(1 << FRAC_BITS)))
    else $error("fraction above one");

  a_total_at_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_RD) && $past(state == S_ACC) |-> (total != '0))
    else $error("emission started with zero pixel total");

endmodule
